// ===== hdl/fdp_pkg.sv =====
package fdp_pkg;

  // number of partial accumulators for the main part of the vector
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

  // float32 patterns
  localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;
  localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
  localparam logic [30:0] INF_MAG   = 31'h7f80_0000;

  // unit scale used for plain adds
  localparam logic signed [7:0] SCALE_ONE = 8'sd1;

  // datapath widths of the shared unit
  localparam int MANT_W  = 32;
  localparam int GUARD_W = 34;
  localparam int ALIGN_W = MANT_W + GUARD_W;
  localparam int SUM_W   = ALIGN_W + 1;

  // request to the shared multiply-add unit: addend + scale * mulcand
  typedef struct packed {
    logic [31:0]       addend;
    logic [31:0]       mulcand;
    logic signed [7:0] scale;
  } fdp_req_t;

  // leading zero count of a 32-bit word (nonzero input)
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n[4:0];
  endfunction

  // leading zero count of the sum word (nonzero input)
  function automatic logic [6:0] lzc_sum(input logic [SUM_W-1:0] v);
    logic [7:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 8'd1;
      end
    end
    return n[6:0];
  endfunction

endpackage

// ===== hdl/fdp_fma_unit.sv =====
module fdp_fma_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fdp_pkg::fdp_req_t req,
  output logic             done,
  output logic [31:0]      result
);
  import fdp_pkg::*;

  logic [5:0] vld;

  // unpack
  logic [7:0]  ea, eb, ea_eff, eb_eff, m_mag;
  logic [22:0] fa, fb;
  logic        sa, sb, sp, m_neg;
  logic        a_nan, a_inf, b_nan, b_inf, p_inf, is_nan;
  logic [23:0] mant_a, mant_b;

  always_comb begin
    sa     = req.addend[31];
    ea     = req.addend[30:23];
    fa     = req.addend[22:0];
    sb     = req.mulcand[31];
    eb     = req.mulcand[30:23];
    fb     = req.mulcand[22:0];
    a_nan  = (ea == 8'hff) && (fa != '0);
    a_inf  = (ea == 8'hff) && (fa == '0);
    b_nan  = (eb == 8'hff) && (fb != '0);
    b_inf  = (eb == 8'hff) && (fb == '0);
    m_neg  = req.scale[7];
    m_mag  = m_neg ? (~req.scale + 8'd1) : req.scale;
    sp     = sb ^ m_neg;
    p_inf  = b_inf && (m_mag != 8'd0);
    is_nan = a_nan || b_nan || (b_inf && (m_mag == 8'd0)) || (a_inf && p_inf && (sa != sp));
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    mant_a = {ea != 8'd0, fa};
    mant_b = {eb != 8'd0, fb};
  end

  // stage 1: exact product and operand setup
  logic               s1_sa, s1_sp, s1_spec;
  logic [31:0]        s1_sval, s1_ma, s1_mp;
  logic signed [10:0] s1_ea, s1_ep;

  always_ff @(posedge clk) begin
    s1_sa   <= sa;
    s1_sp   <= sp;
    s1_spec <= is_nan || a_inf || p_inf;
    s1_sval <= is_nan ? CANON_NAN : (a_inf ? req.addend : {sp, INF_MAG});
    s1_ma   <= {mant_a, 8'd0};
    s1_ea   <= $signed({3'd0, ea_eff}) - 11'sd158;
    s1_mp   <= 32'(mant_b) * 32'(m_mag);
    s1_ep   <= $signed({3'd0, eb_eff}) - 11'sd150;
  end

  // stage 2: normalize both operands
  logic               s2_sa, s2_sp, s2_spec, s2_za, s2_zp;
  logic [31:0]        s2_sval, s2_ma, s2_mp;
  logic signed [10:0] s2_ea, s2_ep;
  logic [4:0]         lz_a, lz_p;

  assign lz_a = lzc32(s1_ma);
  assign lz_p = lzc32(s1_mp);

  always_ff @(posedge clk) begin
    s2_sa   <= s1_sa;
    s2_sp   <= s1_sp;
    s2_spec <= s1_spec;
    s2_sval <= s1_sval;
    s2_za   <= (s1_ma == '0);
    s2_zp   <= (s1_mp == '0);
    s2_ma   <= s1_ma << lz_a;
    s2_mp   <= s1_mp << lz_p;
    s2_ea   <= s1_ea - $signed({6'd0, lz_a});
    s2_ep   <= s1_ep - $signed({6'd0, lz_p});
  end

  // stage 3: order by magnitude and align the smaller operand
  logic                 a_big, s_big, s_small;
  logic [31:0]          m_big, m_small;
  logic signed [10:0]   e_big, e_small, e_diff;
  logic [ALIGN_W-1:0]   wide, aligned;
  logic                 sticky;

  always_comb begin
    a_big   = s2_zp || (!s2_za && ((s2_ea > s2_ep) || ((s2_ea == s2_ep) && (s2_ma >= s2_mp))));
    m_big   = a_big ? s2_ma : s2_mp;
    m_small = a_big ? s2_mp : s2_ma;
    e_big   = a_big ? s2_ea : s2_ep;
    e_small = a_big ? s2_ep : s2_ea;
    s_big   = a_big ? s2_sa : s2_sp;
    s_small = a_big ? s2_sp : s2_sa;
    e_diff  = e_big - e_small;
    wide    = {m_small, {GUARD_W{1'b0}}};
    if ((a_big ? s2_zp : s2_za) || (e_diff >= 11'sd66)) begin
      aligned = '0;
      sticky  = (a_big ? !s2_zp : !s2_za);
    end else begin
      aligned = wide >> e_diff[6:0];
      sticky  = ((aligned << e_diff[6:0]) != wide);
    end
  end

  logic               s3_sub, s3_sign, s3_zs, s3_spec;
  logic [31:0]        s3_sval, s3_big;
  logic [ALIGN_W-1:0] s3_al;
  logic signed [10:0] s3_e;

  always_ff @(posedge clk) begin
    s3_sub  <= s_big ^ s_small;
    s3_sign <= s_big;
    s3_zs   <= (s2_za && s2_zp) ? (s2_sa & s2_sp) : 1'b0;
    s3_spec <= s2_spec;
    s3_sval <= s2_sval;
    s3_big  <= m_big;
    s3_al   <= aligned | {{(ALIGN_W-1){1'b0}}, sticky};
    s3_e    <= e_big;
  end

  // stage 4: add or subtract
  logic [SUM_W-1:0]   big_w, small_w;
  logic               s4_sign, s4_zs, s4_spec;
  logic [31:0]        s4_sval;
  logic [SUM_W-1:0]   s4_sum;
  logic signed [10:0] s4_e;

  assign big_w   = {1'b0, s3_big, {GUARD_W{1'b0}}};
  assign small_w = {1'b0, s3_al};

  always_ff @(posedge clk) begin
    s4_sum  <= s3_sub ? (big_w - small_w) : (big_w + small_w);
    s4_sign <= s3_sign;
    s4_zs   <= s3_zs;
    s4_spec <= s3_spec;
    s4_sval <= s3_sval;
    s4_e    <= s3_e;
  end

  // stage 5: normalize the sum
  logic [6:0]         lz_s;
  logic               s5_sign, s5_zs, s5_spec, s5_zero;
  logic [31:0]        s5_sval;
  logic [SUM_W-1:0]   s5_n;
  logic signed [10:0] s5_bexp;

  assign lz_s = lzc_sum(s4_sum);

  always_ff @(posedge clk) begin
    s5_n    <= s4_sum << lz_s;
    s5_bexp <= s4_e + 11'sd159 - $signed({4'd0, lz_s});
    s5_zero <= (s4_sum == '0);
    s5_sign <= s4_sign;
    s5_zs   <= s4_zs;
    s5_spec <= s4_spec;
    s5_sval <= s4_sval;
  end

  // stage 6: denormalize, round to nearest even, pack
  logic [4:0]         den_sh;
  logic signed [10:0] den_amt;
  logic [SUM_W-1:0]   den_n;
  logic               lost, g_bit, st_bit, rnd;
  logic [23:0]        m24;
  logic [7:0]         field;
  logic [30:0]        packed_mag;
  logic [31:0]        res_next;

  always_comb begin
    den_amt = 11'sd1 - s5_bexp;
    if (s5_bexp >= 11'sd1) den_sh = 5'd0;
    else if (den_amt > 11'sd26) den_sh = 5'd26;
    else den_sh = den_amt[4:0];
    den_n      = s5_n >> den_sh;
    lost       = ((den_n << den_sh) != s5_n);
    m24        = den_n[SUM_W-1 -: 24];
    g_bit      = den_n[SUM_W-25];
    st_bit     = (den_n[SUM_W-26:0] != '0) || lost;
    rnd        = g_bit && (st_bit || m24[0]);
    field      = (s5_bexp >= 11'sd1) ? s5_bexp[7:0] : 8'd0;
    packed_mag = {field, m24[22:0]} + 31'(rnd);
    if (s5_spec) res_next = s5_sval;
    else if (s5_zero) res_next = {s5_zs, 31'd0};
    else if (s5_bexp >= 11'sd255) res_next = {s5_sign, INF_MAG};
    else res_next = {s5_sign, packed_mag};
  end

  always_ff @(posedge clk) begin
    if (vld[4]) result <= res_next;
  end

  // operation tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  assign done = vld[5];

endmodule

// ===== hdl/int8_float_dot_product_unit.sv =====
// Dot product of a signed 8-bit vector with a float32 vector, one element pair
// per request (start while busy is low). The length register sets the vector
// length (0 means 65536); writing it discards any partial vector. All
// arithmetic goes through one shared float multiply-add unit, so an element
// of the main part (index below the length rounded down to four) keeps busy
// high for one multiply-add into its partial sum, and an element of the
// remainder for two (rounded product, then add). The element that closes the
// main part adds a seven-add reduction of the eight partial sums. The result
// appears on dot_result with result_valid high for exactly one cycle, right
// after the last element's work; the receiver cannot stall it, so it must
// take it in that cycle.
module int8_float_dot_product_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic signed [7:0] int_element,
  input  logic [31:0]       float_element,
  output logic [31:0]       dot_result,
  output logic              result_valid
);
  import fdp_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_MAC  = 11'b000_0000_0010,
    ST_PROD = 11'b000_0000_0100,
    ST_TAIL = 11'b000_0000_1000,
    ST_RED0 = 11'b000_0001_0000,
    ST_RED1 = 11'b000_0010_0000,
    ST_RED2 = 11'b000_0100_0000,
    ST_RED3 = 11'b000_1000_0000,
    ST_RED4 = 11'b001_0000_0000,
    ST_RED5 = 11'b010_0000_0000,
    ST_RED6 = 11'b100_0000_0000
  } fdp_state_t;

  fdp_state_t        state;
  logic              issue;
  logic [31:0]       slots [SLOT_COUNT];
  logic [31:0]       tail, temp;
  logic [15:0]       idx, vlen;
  logic signed [7:0] int_reg;
  logic [31:0]       flt_reg;

  fdp_req_t          req;
  logic              unit_done;
  logic [31:0]       unit_res;

  // length bookkeeping
  logic [16:0] len, len4, idx_inc;
  logic        in_main, last4, last, cfg_wr, finish;
  logic [SLOT_BITS-1:0] slot_sel;

  always_comb begin
    len      = (vlen == 16'd0) ? 17'h1_0000 : {1'b0, vlen};
    len4     = {len[16:2], 2'b00};
    idx_inc  = {1'b0, idx} + 17'd1;
    in_main  = ({1'b0, idx} < len4);
    last4    = (idx_inc == len4);
    last     = (idx_inc >= len);
    slot_sel = idx[SLOT_BITS-1:0];
    cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, vlen};
  assign busy   = (state != ST_IDLE);

  // operand select per operation
  always_comb begin
    req = '{addend: slots[0], mulcand: slots[4], scale: SCALE_ONE};
    case (state)
      ST_MAC:  req = '{addend: slots[slot_sel], mulcand: flt_reg, scale: int_reg};
      ST_PROD: req = '{addend: NEG_ZERO, mulcand: flt_reg, scale: int_reg};
      ST_TAIL: req = '{addend: tail, mulcand: temp, scale: SCALE_ONE};
      ST_RED0: req = '{addend: slots[0], mulcand: slots[4], scale: SCALE_ONE};
      ST_RED1: req = '{addend: slots[1], mulcand: slots[5], scale: SCALE_ONE};
      ST_RED2: req = '{addend: slots[2], mulcand: slots[6], scale: SCALE_ONE};
      ST_RED3: req = '{addend: slots[3], mulcand: slots[7], scale: SCALE_ONE};
      ST_RED4: req = '{addend: slots[0], mulcand: slots[1], scale: SCALE_ONE};
      ST_RED5: req = '{addend: slots[2], mulcand: slots[3], scale: SCALE_ONE};
      ST_RED6: req = '{addend: slots[0], mulcand: slots[2], scale: SCALE_ONE};
      default: req = '{addend: slots[0], mulcand: slots[4], scale: SCALE_ONE};
    endcase
  end

  fdp_fma_unit u_fma (
    .clk    (clk),
    .rst    (rst),
    .start  (issue),
    .req    (req),
    .done   (unit_done),
    .result (unit_res)
  );

  // element is complete after this operation
  assign finish = unit_done &&
                  (((state == ST_MAC) && !last4) || (state == ST_TAIL) || (state == ST_RED6));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue        <= 1'b0;
      result_valid <= 1'b0;
      vlen         <= 16'd1;
      idx          <= '0;
      tail         <= '0;
      for (int k = 0; k < SLOT_COUNT; k++) slots[k] <= '0;
    end else begin
      result_valid <= 1'b0;
      issue        <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            int_reg <= int_element;
            flt_reg <= float_element;
            state   <= in_main ? ST_MAC : ST_PROD;
            issue   <= 1'b1;
          end
        end
        default: begin
          if (unit_done) begin
            case (state)
              ST_MAC: begin
                slots[slot_sel] <= unit_res;
                if (last4) begin
                  state <= ST_RED0;
                  issue <= 1'b1;
                end
              end
              ST_PROD: begin
                temp  <= unit_res;
                state <= ST_TAIL;
                issue <= 1'b1;
              end
              ST_TAIL: tail <= unit_res;
              ST_RED0: begin
                slots[0] <= unit_res;
                state    <= ST_RED1;
                issue    <= 1'b1;
              end
              ST_RED1: begin
                slots[1] <= unit_res;
                state    <= ST_RED2;
                issue    <= 1'b1;
              end
              ST_RED2: begin
                slots[2] <= unit_res;
                state    <= ST_RED3;
                issue    <= 1'b1;
              end
              ST_RED3: begin
                slots[3] <= unit_res;
                state    <= ST_RED4;
                issue    <= 1'b1;
              end
              ST_RED4: begin
                slots[0] <= unit_res;
                state    <= ST_RED5;
                issue    <= 1'b1;
              end
              ST_RED5: begin
                slots[2] <= unit_res;
                state    <= ST_RED6;
                issue    <= 1'b1;
              end
              ST_RED6: tail <= unit_res;
              default: state <= ST_IDLE;
            endcase
          end
        end
      endcase

      // element done: emit on the last one, else advance
      if (finish) begin
        state <= ST_IDLE;
        if (last) begin
          dot_result   <= unit_res;
          result_valid <= 1'b1;
          idx          <= '0;
          tail         <= '0;
          for (int k = 0; k < SLOT_COUNT; k++) slots[k] <= '0;
        end else begin
          idx <= idx_inc[15:0];
        end
      end

      // length write starts a fresh vector
      if (cfg_wr) begin
        vlen <= pwdata[15:0];
        idx  <= '0;
        tail <= '0;
        for (int k = 0; k < SLOT_COUNT; k++) slots[k] <= '0;
      end
    end
  end

endmodule
